// ===== hdl/swrap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supercell wrap package
// Shared widths, codes, stage payload types and helper functions.
// ----------------------------------------------------------------------------
package swrap_pkg;

	localparam int PT_W     = 18;
	localparam int VEC_W    = 16;
	localparam int PROD_W   = PT_W + VEC_W;
	localparam int DPROD_W  = 2 * VEC_W;
	localparam int CROSS_W  = PROD_W + 1;
	localparam int DET_W    = DPROD_W + 1;
	localparam int TEST_W   = CROSS_W + 1;
	localparam int SUM_W    = PT_W + 2;
	localparam int STAT_W   = 2;
	localparam int IN_W     = 2 * PT_W;
	localparam int OUT_W    = 2 * PT_W + STAT_W;
	localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 2;

	localparam logic signed [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
	localparam logic signed [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

	typedef enum logic [STAT_W-1:0] {
		ST_INSIDE  = 2'd0,
		ST_SHIFTED = 2'd1,
		ST_NONE    = 2'd2
	} wrap_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_V0_COL = 2'd0,
		CFG_V0_ROW = 2'd1,
		CFG_V1_COL = 2'd2,
		CFG_V1_ROW = 2'd3
	} cfg_index_t;

	// Shift coefficient; the code doubles as an index 0..2 for -1..1.
	typedef enum logic [1:0] {
		SH_NEG  = 2'd0,
		SH_ZERO = 2'd1,
		SH_POS  = 2'd2
	} shift_t;

	typedef struct packed {
		logic signed [PT_W-1:0] row;
		logic signed [PT_W-1:0] col;
	} point_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] v0_col;
		logic signed [VEC_W-1:0] v0_row;
		logic signed [VEC_W-1:0] v1_col;
		logic signed [VEC_W-1:0] v1_row;
	} vecs_t;

	typedef struct packed {
		point_t                    pt;
		logic signed [PROD_W-1:0]  a_pos;
		logic signed [PROD_W-1:0]  a_neg;
		logic signed [PROD_W-1:0]  b_pos;
		logic signed [PROD_W-1:0]  b_neg;
		logic signed [DPROD_W-1:0] d_pos;
		logic signed [DPROD_W-1:0] d_neg;
	} prod_t;

	typedef struct packed {
		point_t                    pt;
		logic signed [CROSS_W-1:0] a;
		logic signed [CROSS_W-1:0] b;
		logic signed [DET_W-1:0]   d;
	} cross_t;

	typedef struct packed {
		point_t       pt;
		wrap_status_t status;
		shift_t       si;
		shift_t       sj;
	} sel_t;

	typedef struct packed {
		point_t       pt;
		wrap_status_t status;
	} result_t;

	// Half-open range test of one scaled coordinate against the determinant.
	function automatic logic in_cell(logic signed [TEST_W-1:0] x, logic signed [DET_W-1:0] d);
		logic signed [TEST_W-1:0] dx;
		logic                     r;
		dx = TEST_W'(d);
		if (d > 0) begin
			r = (x >= 0) && (x < dx);
		end else if (d < 0) begin
			r = (x <= 0) && (x > dx);
		end else begin
			r = 1'b0;
		end
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] shift_term(logic signed [VEC_W-1:0] v,
			shift_t s);
		logic signed [SUM_W-1:0] r;
		case (s)
			SH_NEG:  r = -SUM_W'(v);
			SH_POS:  r = SUM_W'(v);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [PT_W-1:0] sat_pt(logic signed [SUM_W-1:0] v);
		logic signed [PT_W-1:0] r;
		if (v > SUM_W'(PT_MAX)) begin
			r = PT_MAX;
		end else if (v < SUM_W'(PT_MIN)) begin
			r = PT_MIN;
		end else begin
			r = v[PT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/swrap_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supercell wrap input skid buffer
// Holds one word so that the input ready is a register output.
// ----------------------------------------------------------------------------
module swrap_skid import swrap_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  point_t in_pt,
	input  logic   en,
	output logic   out_valid,
	output point_t out_pt
);

	logic   skid_vld_q;
	point_t skid_pt_q;

	assign in_ready  = ~skid_vld_q;
	assign out_valid = skid_vld_q | in_valid;
	assign out_pt    = skid_vld_q ? skid_pt_q : in_pt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (in_valid && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_valid && !skid_vld_q) begin
			skid_pt_q <= in_pt;
		end
	end

endmodule

// ===== hdl/swrap_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supercell wrap product stage
// Forms the cross-product terms of the point and of the lattice vectors.
// ----------------------------------------------------------------------------
module swrap_mul import swrap_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  vecs_t  vecs,
	input  logic   in_valid,
	input  point_t in_pt,
	output logic   out_valid,
	output prod_t  out_prod
);

	logic  vld_s1;
	prod_t prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.pt    <= in_pt;
			prod_s1.a_pos <= in_pt.col * vecs.v1_row;
			prod_s1.a_neg <= in_pt.row * vecs.v1_col;
			prod_s1.b_pos <= in_pt.row * vecs.v0_col;
			prod_s1.b_neg <= in_pt.col * vecs.v0_row;
			prod_s1.d_pos <= vecs.v0_col * vecs.v1_row;
			prod_s1.d_neg <= vecs.v1_col * vecs.v0_row;
		end
	end

	assign out_valid = vld_s1;
	assign out_prod  = prod_s1;

endmodule

// ===== hdl/swrap_sel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supercell wrap cell test
// Forms the cell coordinates, then picks the first shift that lands inside.
// ----------------------------------------------------------------------------
module swrap_sel import swrap_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  prod_t  in_prod,
	output logic   out_valid,
	output sel_t   out_sel
);

	logic   vld_s2;
	cross_t cross_s2;
	logic   vld_s3;
	sel_t   sel_s3;

	logic [2:0] in_a;
	logic [2:0] in_b;
	logic       found;
	sel_t       sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= in_valid;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_s2.pt <= in_prod.pt;
			cross_s2.a  <= CROSS_W'(in_prod.a_pos) - CROSS_W'(in_prod.a_neg);
			cross_s2.b  <= CROSS_W'(in_prod.b_pos) - CROSS_W'(in_prod.b_neg);
			cross_s2.d  <= DET_W'(in_prod.d_pos) - DET_W'(in_prod.d_neg);
			sel_s3      <= sel_d;
		end
	end

	// A shift by i*v0 + j*v1 moves the cell coordinates by i*D and j*D.
	always_comb begin
		in_a[0] = in_cell(TEST_W'(cross_s2.a) - TEST_W'(cross_s2.d), cross_s2.d);
		in_a[1] = in_cell(TEST_W'(cross_s2.a), cross_s2.d);
		in_a[2] = in_cell(TEST_W'(cross_s2.a) + TEST_W'(cross_s2.d), cross_s2.d);
		in_b[0] = in_cell(TEST_W'(cross_s2.b) - TEST_W'(cross_s2.d), cross_s2.d);
		in_b[1] = in_cell(TEST_W'(cross_s2.b), cross_s2.d);
		in_b[2] = in_cell(TEST_W'(cross_s2.b) + TEST_W'(cross_s2.d), cross_s2.d);
	end

	always_comb begin
		found        = 1'b0;
		sel_d.pt     = cross_s2.pt;
		sel_d.status = ST_NONE;
		sel_d.si     = SH_ZERO;
		sel_d.sj     = SH_ZERO;
		if (in_a[1] && in_b[1]) begin
			sel_d.status = ST_INSIDE;
		end else begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (!found && in_a[i] && in_b[j]) begin
						found        = 1'b1;
						sel_d.status = ST_SHIFTED;
						sel_d.si     = shift_t'(2'(i));
						sel_d.sj     = shift_t'(2'(j));
					end
				end
			end
		end
	end

	assign out_valid = vld_s3;
	assign out_sel   = sel_s3;

endmodule

// ===== hdl/swrap_shift.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supercell wrap shift stage
// Applies the chosen lattice shift and saturates the result coordinates.
// ----------------------------------------------------------------------------
module swrap_shift import swrap_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  vecs_t   vecs,
	input  logic    in_valid,
	input  sel_t    in_sel,
	output logic    out_valid,
	output result_t out_res
);

	logic                    vld_s4;
	result_t                 res_s4;
	logic signed [SUM_W-1:0] col_sum;
	logic signed [SUM_W-1:0] row_sum;

	always_comb begin
		col_sum = SUM_W'(in_sel.pt.col) + shift_term(vecs.v0_col, in_sel.si)
			+ shift_term(vecs.v1_col, in_sel.sj);
		row_sum = SUM_W'(in_sel.pt.row) + shift_term(vecs.v0_row, in_sel.si)
			+ shift_term(vecs.v1_row, in_sel.sj);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4.pt.col <= sat_pt(col_sum);
			res_s4.pt.row <= sat_pt(row_sum);
			res_s4.status <= in_sel.status;
		end
	end

	assign out_valid = vld_s4;
	assign out_res   = res_s4;

endmodule

// ===== hdl/supercell_periodic_wrap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supercell periodic wrap
// Folds a lattice point into the half-open supercell spanned by two vectors.
// ----------------------------------------------------------------------------
// The block takes one point per clock while the output is not stalled and
// returns one word per point, in order. Each word passes four register stages
// after its point is accepted: a product stage, a cross-product stage, a
// cell-test stage and a shift stage, each of which advances whenever the
// output register is empty or being taken.
// The input goes through a one-word skid buffer, so input ready depends only
// on registers. Write the lattice vectors only while no point is in flight.
module supercell_periodic_wrap import swrap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // point_col, point_row, zero fill
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // wrapped_col, wrapped_row, wrap_status, zero fill
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [VEC_W-1:0]      cfg_data
);

	vecs_t   vecs_q;
	logic    en;
	point_t  in_pt;
	logic    skid_valid;
	point_t  skid_pt;
	logic    prod_valid;
	prod_t   prod;
	logic    sel_valid;
	sel_t    sel;
	logic    res_valid;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vecs_q.v0_col <= VEC_W'(1);
			vecs_q.v0_row <= '0;
			vecs_q.v1_col <= '0;
			vecs_q.v1_row <= VEC_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_V0_COL: vecs_q.v0_col <= cfg_data;
				CFG_V0_ROW: vecs_q.v0_row <= cfg_data;
				CFG_V1_COL: vecs_q.v1_col <= cfg_data;
				CFG_V1_ROW: vecs_q.v1_row <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en        = ~res_valid | m_tready;
	assign in_pt.col = s_tdata[PT_W-1:0];
	assign in_pt.row = s_tdata[2*PT_W-1:PT_W];

	swrap_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pt     (in_pt),
		.en        (en),
		.out_valid (skid_valid),
		.out_pt    (skid_pt)
	);

	swrap_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vecs      (vecs_q),
		.in_valid  (skid_valid),
		.in_pt     (skid_pt),
		.out_valid (prod_valid),
		.out_prod  (prod)
	);

	swrap_sel u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prod_valid),
		.in_prod   (prod),
		.out_valid (sel_valid),
		.out_sel   (sel)
	);

	swrap_shift u_shift (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vecs      (vecs_q),
		.in_valid  (sel_valid),
		.in_sel    (sel),
		.out_valid (res_valid),
		.out_res   (res)
	);

	assign m_tvalid = res_valid;
	assign m_tdata  = {{(OUT_DATA_W-OUT_W){1'b0}}, res.status, res.pt.row, res.pt.col};

endmodule

// ===== bench/tb_supercell_periodic_wrap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supercell periodic wrap testbench
// Streams lattice points through the fold block under a series of lattice
// vector settings, with random input gaps and output stalls, and checks every
// output word against an integer model of the cell test or a fixed expected word.
// ----------------------------------------------------------------------------
module tb_supercell_periodic_wrap;
	import swrap_pkg::*;

	localparam int  RAND_PHASES = 16;
	localparam int  PHASE_ITEMS = 25;
	localparam int  HOLD_AT     = 110;
	localparam int  HOLD_LEN    = 80;
	localparam int  DRAIN_WAIT  = 10;
	localparam int  CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic signed [PT_W-1:0] col;
		logic signed [PT_W-1:0] row;
		wrap_status_t           status;
	} fold_t;

	typedef struct {
		bit                     is_cfg;
		cfg_index_t             idx;
		logic [VEC_W-1:0]       val;
		logic signed [PT_W-1:0] pc;
		logic signed [PT_W-1:0] pr;
		bit                     known;
		fold_t                  want;
	} drive_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_index_t            cfg_index = CFG_V0_COL;
	logic [VEC_W-1:0]      cfg_data = '0;

	longint lat_v0_col = 1;
	longint lat_v0_row = 0;
	longint lat_v1_col = 0;
	longint lat_v1_row = 1;

	fold_t      folds_due[$];
	drive_row_t dir_rows[$];
	bit         no_gaps = 1'b0;
	int         mism_cnt = 0;
	int         words_seen = 0;
	int         hold_left = 0;
	bit         held = 1'b0;
	int         cyc = 0;
	int         settings_cnt = 0;
	int         n_inside = 0;
	int         n_shifted = 0;
	int         n_none = 0;

	supercell_periodic_wrap i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic signed [PT_W-1:0] clamp_pt(longint v);
		longint r;
		r = v;
		if (r > 131071) r = 131071;
		if (r < -131072) r = -131072;
		return r[PT_W-1:0];
	endfunction

	function automatic bit in_supercell(longint pc, longint pr);
		longint d, a, b;
		d = lat_v0_col * lat_v1_row - lat_v1_col * lat_v0_row;
		a = pc * lat_v1_row - pr * lat_v1_col;
		b = lat_v0_col * pr - lat_v0_row * pc;
		if (d > 0) return a >= 0 && a < d && b >= 0 && b < d;
		if (d < 0) return a <= 0 && a > d && b <= 0 && b > d;
		return 1'b0;
	endfunction

	function automatic fold_t fold_point(logic signed [PT_W-1:0] c, logic signed [PT_W-1:0] r);
		fold_t  res;
		longint pc, pr, rc, rr, dc, dr;
		pc = c;
		pr = r;
		rc = pc;
		rr = pr;
		res.status = ST_NONE;
		if (in_supercell(pc, pr)) begin
			res.status = ST_INSIDE;
		end else begin
			for (int i = -1; i <= 1; i++) begin
				for (int j = -1; j <= 1; j++) begin
					if (res.status == ST_NONE && !(i == 0 && j == 0)) begin
						dc = i * lat_v0_col + j * lat_v1_col;
						dr = i * lat_v0_row + j * lat_v1_row;
						if (in_supercell(pc + dc, pr + dr)) begin
							rc = pc + dc;
							rr = pr + dr;
							res.status = ST_SHIFTED;
						end
					end
				end
			end
		end
		res.col = clamp_pt(rc);
		res.row = clamp_pt(rr);
		return res;
	endfunction

	function automatic void add_cfg(cfg_index_t idx, logic [VEC_W-1:0] val);
		drive_row_t row;
		row = '{idx: CFG_V0_COL, default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_pt(logic signed [PT_W-1:0] pc, logic signed [PT_W-1:0] pr);
		drive_row_t row;
		row = '{idx: CFG_V0_COL, default: '0};
		row.pc = pc;
		row.pr = pr;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_known(logic signed [PT_W-1:0] pc, logic signed [PT_W-1:0] pr,
			logic signed [PT_W-1:0] ec, logic signed [PT_W-1:0] er, wrap_status_t es);
		drive_row_t row;
		row = '{idx: CFG_V0_COL, default: '0};
		row.pc = pc;
		row.pr = pr;
		row.known = 1'b1;
		row.want.col = ec;
		row.want.row = er;
		row.want.status = es;
		dir_rows.push_back(row);
	endfunction

	task automatic write_lattice(cfg_index_t idx, logic [VEC_W-1:0] val);
		s_tvalid <= 1'b0;
		while (folds_due.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_V0_COL: lat_v0_col = $signed(val);
			CFG_V0_ROW: lat_v0_row = $signed(val);
			CFG_V1_COL: lat_v1_col = $signed(val);
			CFG_V1_ROW: lat_v1_row = $signed(val);
			default: ;
		endcase
	endtask

	task automatic send_point(logic signed [PT_W-1:0] pc, logic signed [PT_W-1:0] pr,
			bit known, fold_t want);
		cfg_valid <= 1'b0;
		while (!no_gaps && $urandom_range(99) < 22) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, pr, pc};
		do @(posedge clk); while (!s_tready);
		folds_due.push_back(known ? want : fold_point(pc, pr));
	endtask

	task automatic write_all(longint v0c, longint v0r, longint v1c, longint v1r);
		write_lattice(CFG_V0_COL, v0c[VEC_W-1:0]);
		write_lattice(CFG_V0_ROW, v0r[VEC_W-1:0]);
		write_lattice(CFG_V1_COL, v1c[VEC_W-1:0]);
		write_lattice(CFG_V1_ROW, v1r[VEC_W-1:0]);
		settings_cnt++;
	endtask

	always @(posedge clk) begin
		logic signed [PT_W-1:0] got_col, got_row;
		logic [STAT_W-1:0]      got_st;
		fold_t                  want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_col = m_tdata[PT_W-1:0];
				got_row = m_tdata[2*PT_W-1:PT_W];
				got_st = m_tdata[2*PT_W+STAT_W-1:2*PT_W];
				words_seen++;
				if (folds_due.size() == 0) begin
					$error("output word with no point pending");
					mism_cnt++;
				end else begin
					want = folds_due.pop_front();
					case (want.status)
						ST_INSIDE:  n_inside++;
						ST_SHIFTED: n_shifted++;
						default:    n_none++;
					endcase
					if (got_col !== want.col) begin
						$error("wrapped_col expected %0d got %0d", want.col, got_col);
						mism_cnt++;
					end
					if (got_row !== want.row) begin
						$error("wrapped_row expected %0d got %0d", want.row, got_row);
						mism_cnt++;
					end
					if (got_st !== want.status) begin
						$error("wrap_status expected %0d got %0d", want.status, got_st);
						mism_cnt++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!held && words_seen >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_LEN;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_gaps || ($urandom_range(99) >= 22);
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		longint     v[4];
		longint     pc, pr;
		int         kind, n0, n1, m, p, ofs;
		drive_row_t row;
		fold_t      none_fold;

		none_fold = '0;

		// Reset lattice is the unit square, so only the origin is inside.
		add_known(0, 0, 0, 0, ST_INSIDE);
		add_known(1, 0, 0, 0, ST_SHIFTED);
		add_known(0, 1, 0, 0, ST_SHIFTED);
		add_pt(-1, -1);
		add_known(131071, 131071, 131071, 131071, ST_NONE);
		add_known(-131072, -131072, -131072, -131072, ST_NONE);
		add_known(131071, -131072, 131071, -131072, ST_NONE);
		add_known(-131072, 131071, -131072, 131071, ST_NONE);
		add_known(2, 0, 2, 0, ST_NONE);
		add_cfg(CFG_V0_COL, 16'h8000);
		add_cfg(CFG_V0_ROW, 16'h7fff);
		add_cfg(CFG_V1_COL, 16'h7fff);
		add_cfg(CFG_V1_ROW, 16'h8000);
		add_known(0, 0, 0, 0, ST_INSIDE);
		add_pt(-1, 0);
		add_pt(32767, 0);
		add_pt(-32768, 32767);
		add_pt(131071, -131072);
		add_pt(-100, -100);
		add_pt(40000, -40000);
		// Parallel vectors: no point has an image.
		add_cfg(CFG_V0_COL, 16'd3);
		add_cfg(CFG_V0_ROW, 16'd5);
		add_cfg(CFG_V1_COL, 16'd6);
		add_cfg(CFG_V1_ROW, 16'd10);
		add_known(0, 0, 0, 0, ST_NONE);
		add_known(4, 7, 4, 7, ST_NONE);
		add_known(-131072, 131071, -131072, 131071, ST_NONE);
		// Negative determinant.
		add_cfg(CFG_V0_COL, 16'h7fff);
		add_cfg(CFG_V0_ROW, 16'h0000);
		add_cfg(CFG_V1_COL, 16'h0000);
		add_cfg(CFG_V1_ROW, 16'h8000);
		add_known(0, 0, 0, 0, ST_INSIDE);
		add_pt(100, -100);
		add_pt(32767, 0);
		add_pt(-5, 5);
		add_pt(0, -32768);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		settings_cnt = 1;
		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			if (row.is_cfg) begin
				write_lattice(row.idx, row.val);
				if (row.idx == CFG_V1_ROW) settings_cnt++;
			end else begin
				send_point(row.pc, row.pr, row.known, row.want);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			kind = $urandom_range(9);
			if (kind <= 5) begin
				for (int q = 0; q < 4; q++) v[q] = int'($urandom_range(24)) - 12;
			end else if (kind <= 7) begin
				for (int q = 0; q < 4; q++) v[q] = $signed(16'($urandom));
			end else if (kind == 8) begin
				v[0] = int'($urandom_range(16)) - 8;
				v[1] = int'($urandom_range(16)) - 8;
				m = int'($urandom_range(4)) - 2;
				v[2] = m * v[0];
				v[3] = m * v[1];
			end else begin
				v[0] = -int'($urandom_range(1, 300));
				v[1] = 0;
				v[2] = 0;
				v[3] = $urandom_range(1, 300);
			end
			write_all(v[0], v[1], v[2], v[3]);
			no_gaps = (ph == 4);
			for (int it = 0; it < PHASE_ITEMS; it++) begin
				if (ph == 10 && it == 12) begin
					s_tvalid <= 1'b0;
					while (folds_due.size() != 0) @(posedge clk);
				end
				p = $urandom_range(99);
				if (p < 10) begin
					pc = $signed(18'($urandom));
					pr = $signed(18'($urandom));
				end else begin
					if (p < 35) begin
						n0 = 16 * (int'($urandom_range(3)) - 1);
						n1 = 16 * (int'($urandom_range(3)) - 1);
						ofs = 1;
					end else begin
						n0 = int'($urandom_range(64)) - 24;
						n1 = int'($urandom_range(64)) - 24;
						ofs = 0;
					end
					pc = (n0 * lat_v0_col + n1 * lat_v1_col) / 16;
					pr = (n0 * lat_v0_row + n1 * lat_v1_row) / 16;
					if (ofs != 0) begin
						pc += int'($urandom_range(2)) - 1;
						pr += int'($urandom_range(2)) - 1;
					end
				end
				send_point(clamp_pt(pc), clamp_pt(pr), 1'b0, none_fold);
			end
		end
		no_gaps = 1'b0;

		s_tvalid <= 1'b0;
		while (folds_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Folded %0d points under %0d lattice settings.", words_seen, settings_cnt);
		$display("Already inside: %0d, shifted: %0d, no image: %0d.", n_inside, n_shifted,
			n_none);
		if (mism_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== supercell_periodic_wrap.f =====
hdl/swrap_pkg.sv
hdl/swrap_skid.sv
hdl/swrap_mul.sv
hdl/swrap_sel.sv
hdl/swrap_shift.sv
hdl/supercell_periodic_wrap.sv
bench/tb_supercell_periodic_wrap.sv
